// ===== design/aec_pkg.sv =====
package aec_pkg;

  localparam int SAMPLE_W = 24;
  localparam int WIDE_W   = SAMPLE_W + 2;
  localparam int DESC_W   = 50;
  localparam int NUM_REGS = 8;
  localparam int INDEX_W  = 4;
  localparam int DIV_STEP = 4;

  typedef enum logic [1:0] {
    KIND_BYPASS = 2'd0,
    KIND_BOOST  = 2'd1,
    KIND_CLIP   = 2'd2,
    KIND_CRUSH  = 2'd3
  } kind_t;

  typedef logic [DESC_W-1:0] desc_t;

  // One slot of the remainder pipeline inside an effect stage
  typedef struct packed {
    logic                       vld;
    logic signed [SAMPLE_W-1:0] s;
    logic signed [SAMPLE_W-1:0] r;
    logic signed [SAMPLE_W-1:0] simple;
    logic                       crush;
    logic [SAMPLE_W-1:0]        dvd;
    logic [SAMPLE_W-1:0]        dr;
    logic [SAMPLE_W-1:0]        rem;
  } lane_t;

  function automatic logic signed [SAMPLE_W-1:0] sat(input logic signed [WIDE_W-1:0] v,
                                                     input logic signed [WIDE_W-1:0] hi,
                                                     input logic signed [WIDE_W-1:0] lo);
    logic signed [WIDE_W-1:0] c;
    begin
      if (v > hi) c = hi;
      else if (v < lo) c = lo;
      else c = v;
      return c[SAMPLE_W-1:0];
    end
  endfunction

endpackage

// ===== design/audio_effect_chain.sv =====
// Throughput: one sample per cycle while the output is not stalled; each
// effect stage is a decode register, a 4-bits-per-cycle remainder pipeline
// and a result register.
// The whole pipeline advances together and holds while the output waits.
// Reset (synchronous, active high) clears all valid bits and sets every
// stage descriptor to bypass.
module audio_effect_chain import aec_pkg::*; #(
  parameter int STAGE_COUNT = 8,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] sample_out,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [INDEX_W-1:0]         cfg_index,
  input  logic [DESC_W-1:0]          cfg_data
);

  localparam int DEPTH = STAGE_COUNT * (SAMPLE_W / DIV_STEP + 2);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic signed [WIDE_W-1:0] HI = (WIDE_W'(1) <<< (SAMPLE_BITS - 1)) - WIDE_W'(1);
  localparam logic signed [WIDE_W-1:0] LO = -HI - WIDE_W'(1);

  desc_t stage_reg [NUM_REGS];
  logic advance;
  logic vld [STAGE_COUNT+1];
  logic signed [SAMPLE_W-1:0] smp [STAGE_COUNT+1];
  logic [CNT_W-1:0] count;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign in_ready  = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) stage_reg[i] <= '0;
    end else if (cfg_valid && (cfg_index < INDEX_W'(NUM_REGS))) begin
      stage_reg[cfg_index[$clog2(NUM_REGS)-1:0]] <= cfg_data;
    end
  end

  assign vld[0] = in_valid;
  assign smp[0] = sat(WIDE_W'(sample_in), HI, LO);

  for (genvar g = 0; g < STAGE_COUNT; g++) begin : g_stage
    aec_stage #(.SAMPLE_BITS(SAMPLE_BITS)) u_stage (
      .clk    (clk),
      .rst    (rst),
      .en     (advance),
      .in_vld (vld[g]),
      .in_s   (smp[g]),
      .desc   (stage_reg[g]),
      .out_vld(vld[g+1]),
      .out_s  (smp[g+1])
    );
  end

  assign out_valid  = vld[STAGE_COUNT];
  assign sample_out = smp[STAGE_COUNT];

  // Requests in flight, for checking only
  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else count <= count + CNT_W'(in_valid && in_ready) - CNT_W'(out_valid && out_ready);
  end

  a_no_ghost: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> count != '0) else $error("output without a request in flight");
  a_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("more requests in flight than slots");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready) else $error("input held without a stall");
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("valid after reset");

endmodule

// ===== design/aec_stage.sv =====
module aec_stage import aec_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic signed [SAMPLE_W-1:0] in_s,
  input  desc_t                      desc,
  output logic                       out_vld,
  output logic signed [SAMPLE_W-1:0] out_s
);

  localparam int DIV_REGS = SAMPLE_W / DIV_STEP;
  localparam logic signed [WIDE_W-1:0] HI = (WIDE_W'(1) <<< (SAMPLE_BITS - 1)) - WIDE_W'(1);
  localparam logic signed [WIDE_W-1:0] LO = -HI - WIDE_W'(1);

  lane_t pipe [DIV_REGS+1];
  lane_t pipe_next [DIV_REGS+1];

  kind_t kind;
  logic signed [SAMPLE_W-1:0] a, b;
  logic signed [WIDE_W-1:0] sx, raw;

  assign kind = kind_t'(desc[49:48]);
  assign a    = desc[47:24];
  assign b    = desc[23:0];
  assign sx   = WIDE_W'(in_s);

  // Decode: bypass, boost and clip finish here; crush sets up the divider
  always_comb begin
    logic [SAMPLE_W:0] t;
    raw = sx;
    case (kind)
      KIND_BOOST: raw = sx + WIDE_W'(a);
      KIND_CLIP: begin
        if (in_s > b) raw = WIDE_W'(b);
        else if (in_s < a) raw = WIDE_W'(a);
      end
      default: raw = sx;
    endcase
    pipe_next[0].vld    = in_vld;
    pipe_next[0].s      = in_s;
    pipe_next[0].r      = a;
    pipe_next[0].simple = sat(raw, HI, LO);
    pipe_next[0].crush  = (kind == KIND_CRUSH) && (a != '0);
    pipe_next[0].dvd    = in_s[SAMPLE_W-1] ? SAMPLE_W'(-in_s) : SAMPLE_W'(in_s);
    pipe_next[0].dr     = a[SAMPLE_W-1] ? SAMPLE_W'(-a) : SAMPLE_W'(a);
    pipe_next[0].rem    = '0;

    // Restoring remainder, DIV_STEP bits per register
    for (int k = 0; k < DIV_REGS; k++) begin
      pipe_next[k+1] = pipe[k];
      for (int j = 0; j < DIV_STEP; j++) begin
        t = {pipe_next[k+1].rem, pipe_next[k+1].dvd[SAMPLE_W-1]};
        pipe_next[k+1].dvd = pipe_next[k+1].dvd << 1;
        if (t >= {1'b0, pipe_next[k+1].dr}) t = t - {1'b0, pipe_next[k+1].dr};
        pipe_next[k+1].rem = t[SAMPLE_W-1:0];
      end
    end
  end

  lane_t last;
  logic signed [WIDE_W-1:0] mag, rf, crushed;
  logic signed [SAMPLE_W-1:0] out_s_next;

  assign last = pipe[DIV_REGS];

  // Turn the magnitude remainder into a floored one, then subtract
  always_comb begin
    mag = WIDE_W'({2'b00, last.rem});
    rf  = last.s[SAMPLE_W-1] ? -mag : mag;
    if ((last.rem != '0) && (last.s[SAMPLE_W-1] != last.r[SAMPLE_W-1]))
      rf = rf + WIDE_W'(last.r);
    crushed    = WIDE_W'(last.s) - rf;
    out_s_next = last.crush ? sat(crushed, HI, LO) : last.simple;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_REGS; k++) pipe[k].vld <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      for (int k = 0; k <= DIV_REGS; k++) pipe[k] <= pipe_next[k];
      out_vld <= last.vld;
      out_s   <= out_s_next;
    end
  end

endmodule

// ===== tb/sv/aec_checker.sv =====
module aec_checker import aec_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic signed [SAMPLE_W-1:0] sample_out,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [INDEX_W-1:0]         cfg_index,
  input  logic [DESC_W-1:0]          cfg_data,
  output int                         fail_count,
  output int                         pending
);

  desc_t stage_desc [NUM_REGS];
  logic signed [SAMPLE_W-1:0] expected_samples [$];

  function automatic longint clamp24(input longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic longint floor_crush(input longint s, input longint r);
    longint q;
    longint rm;
    q = s / r;
    rm = s % r;
    if (rm != 0 && ((rm < 0) != (r < 0))) q = q - 1;
    return q * r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] run_chain(input logic signed [SAMPLE_W-1:0] x);
    longint s;
    longint a;
    longint b;
    longint r;
    kind_t k;
    s = x;
    for (int i = 0; i < NUM_REGS; i++) begin
      k = kind_t'(stage_desc[i][49:48]);
      a = $signed(stage_desc[i][47:24]);
      b = $signed(stage_desc[i][23:0]);
      r = s;
      case (k)
        KIND_BOOST: r = s + a;
        KIND_CLIP: begin
          // max test wins when the window is inverted
          if (s > b) r = b;
          else if (s < a) r = a;
        end
        KIND_CRUSH: if (a != 0) r = floor_crush(s, a);
        default: r = s;
      endcase
      s = clamp24(r);
    end
    return s[SAMPLE_W-1:0];
  endfunction

  assign pending = expected_samples.size();

  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) stage_desc[i] <= '0;
      expected_samples.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < NUM_REGS)
        stage_desc[cfg_index[$clog2(NUM_REGS)-1:0]] <= cfg_data;
      if (in_valid && in_ready) expected_samples.push_back(run_chain(sample_in));
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected sample_out: actual %0d", sample_out);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_samples.pop_front();
          if (want !== sample_out) begin
            $error("sample_out mismatch: expected %0d actual %0d", want, sample_out);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/sv/tb_audio_effect_chain.sv =====
module tb_audio_effect_chain;
  import aec_pkg::*;

  localparam int DRAIN_CYCLES = 200;
  localparam int STALL_LIMIT  = 5000;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample_in = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [INDEX_W-1:0]         cfg_index = '0;
  logic [DESC_W-1:0]          cfg_data = '0;
  int                         fail_count;
  int                         pending;
  bit                         calm = 1'b0;
  int                         quiet_cycles = 0;

  always #5 clk = ~clk;

  audio_effect_chain DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .sample_in(sample_in),
    .out_valid(out_valid), .out_ready(out_ready), .sample_out(sample_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  aec_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .sample_in(sample_in),
    .out_valid(out_valid), .out_ready(out_ready), .sample_out(sample_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
  );

  // receiver: random stall bursts, none once calm
  initial begin
    int n;
    @(posedge clk iff !rst);
    forever begin
      n = $urandom_range(1, 18);
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic desc_t make_desc(input kind_t k, input logic [23:0] a, input logic [23:0] b);
    return {k, a, b};
  endfunction

  function automatic logic [23:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($signed($urandom_range(0, 16)) - 8);
      3: return 24'($urandom_range(1, 4096));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic write_stage(input logic [INDEX_W-1:0] idx, input desc_t d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait for the pipeline to empty before touching the stage registers
  task automatic drain_pipe();
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_sample(input logic [23:0] v);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
  endtask

  task automatic random_stages();
    kind_t k;
    for (int i = 0; i < NUM_REGS; i++) begin
      k = kind_t'($urandom_range(0, 3));
      write_stage(i[INDEX_W-1:0], make_desc(k, pick_value(), pick_value()));
    end
  endtask

  initial begin
    logic [23:0] edge_samples [6];
    edge_samples = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF, 24'h000001, 24'h123456};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset state: all bypass
    foreach (edge_samples[i]) send_sample(edge_samples[i]);
    idle_input();
    drain_pipe();

    // boost saturation, inverted clip window, negative and zero crush resolution
    write_stage(4'd0, make_desc(KIND_BOOST, 24'h7FFFFF, 24'h0));
    write_stage(4'd1, make_desc(KIND_CLIP, 24'd1000, 24'hFFFC18));
    write_stage(4'd2, make_desc(KIND_CRUSH, 24'hFFFFF9, 24'h0));
    write_stage(4'd3, make_desc(KIND_CRUSH, 24'h0, 24'h0));
    write_stage(4'd4, make_desc(KIND_BOOST, 24'h800000, 24'h0));
    write_stage(4'd5, make_desc(KIND_CLIP, 24'h800000, 24'h7FFFFF));
    write_stage(4'd6, make_desc(KIND_CRUSH, 24'd3, 24'h0));
    write_stage(4'd7, make_desc(KIND_BYPASS, 24'hFFFFFF, 24'hFFFFFF));
    write_stage(4'hF, make_desc(KIND_BOOST, 24'd5, 24'h0));
    foreach (edge_samples[i]) send_sample(edge_samples[i]);
    idle_input();
    drain_pipe();

    write_stage(4'd0, make_desc(KIND_CLIP, 24'hFFFF00, 24'h000100));
    write_stage(4'd1, make_desc(KIND_CRUSH, 24'h800000, 24'h0));
    write_stage(4'd4, make_desc(KIND_BOOST, 24'h000010, 24'h0));
    for (int i = 0; i < 8; i++) send_sample(pick_value());
    idle_input();
    drain_pipe();

    for (int phase = 0; phase < 10; phase++) begin
      random_stages();
      if (phase == 9) calm = 1'b1;
      for (int j = 0; j < 74; j++) begin
        send_sample(pick_value());
        if (j == 30 && phase == 2) begin
          idle_input();
          while (pending != 0) @(posedge clk);
        end
      end
      idle_input();
      drain_pipe();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
